// ===== sv/nmru_victim_selector_top_defines.svh =====
//------------------------------------------------------------------------------
// nmru_victim_selector_top_defines.svh
// Assertion macros used by nmru_back of the replacement selector RTL.
//------------------------------------------------------------------------------
`ifndef NMRU_VICTIM_SELECTOR_TOP_DEFINES_SVH
`define NMRU_VICTIM_SELECTOR_TOP_DEFINES_SVH

// condition holds on every clock out of reset
`define NMRU_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define NMRU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== sv/nmru_pkg.sv =====
//------------------------------------------------------------------------------
// nmru_pkg
// Shared types, request codes and the LFSR step of the NMRU selector.
//------------------------------------------------------------------------------
package nmru_pkg;

	localparam int unsigned SET_W   = 6;
	localparam int unsigned WAYF_W  = 2;
	localparam int unsigned TICK_W  = 32;
	localparam int unsigned LFSR_W  = 16;
	localparam int unsigned IN_W    = 48;
	localparam int unsigned OUT_W   = 8;
	localparam int unsigned QDEPTH  = 2;

	localparam logic [LFSR_W-1:0] SEED_RESET = 16'd44257;
	localparam logic [LFSR_W-1:0] LFSR_TAPS  = 16'hB400;

	localparam logic [1:0] REQ_CLEAR  = 2'd0;
	localparam logic [1:0] REQ_TOUCH  = 2'd1;
	localparam logic [1:0] REQ_VICTIM = 2'd2;

	localparam logic REG_SEED = 1'b0;

	typedef enum logic [1:0] {
		KIND_NOP,
		KIND_WRITE,
		KIND_VICTIM
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [SET_W-1:0]   set;
		logic [WAYF_W-1:0]  way;
		logic [TICK_W-1:0]  tick;
	} entry_t;

	function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] x);
		logic [LFSR_W-1:0] sh;
		sh = x >> 1;
		return x[0] ? (sh ^ LFSR_TAPS) : sh;
	endfunction

endpackage

// ===== sv/nmru_front.sv =====
//------------------------------------------------------------------------------
// nmru_front
// Accepts request words, decodes them and pushes queue entries.
//------------------------------------------------------------------------------
module nmru_front #(
	parameter int unsigned NUM_SETS = 64,
	parameter int unsigned NUM_WAYS = 4
) (
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// req_type[1:0], set_index[7:2], way_index[9:8], now_tick[41:10], zero pad
	input  logic [nmru_pkg::IN_W-1:0]     s_tdata,
	input  logic                          clearing,
	input  logic                          q_full,
	output logic                          q_push,
	output nmru_pkg::entry_t              q_entry
);
	import nmru_pkg::*;

	logic [SET_W-1:0]  set_mod [2**SET_W];
	logic [1:0]        req;
	logic [SET_W-1:0]  set_in;
	logic [WAYF_W-1:0] way_in;
	logic [TICK_W-1:0] tick_in;
	logic              way_ok;

	for (genvar i = 0; i < 2**SET_W; i++) begin : g_set_mod
		localparam int unsigned MODV = i % NUM_SETS;
		assign set_mod[i] = SET_W'(MODV);
	end

	assign req     = s_tdata[1:0];
	assign set_in  = s_tdata[7:2];
	assign way_in  = s_tdata[9:8];
	assign tick_in = s_tdata[41:10];
	assign way_ok  = int'(way_in) < NUM_WAYS;

	assign s_tready = !q_full && !clearing;
	assign q_push   = s_tvalid && s_tready;

	always_comb begin
		q_entry.set  = set_mod[set_in];
		q_entry.way  = way_in;
		q_entry.tick = '0;
		q_entry.kind = KIND_NOP;
		case (req)
			REQ_CLEAR: begin
				if (way_ok) q_entry.kind = KIND_WRITE;
			end
			REQ_TOUCH: begin
				if (way_ok) q_entry.kind = KIND_WRITE;
				q_entry.tick = tick_in;
			end
			REQ_VICTIM: begin
				q_entry.kind = KIND_VICTIM;
			end
			default: begin
				q_entry.kind = KIND_NOP;
			end
		endcase
	end

endmodule

// ===== sv/nmru_queue.sv =====
//------------------------------------------------------------------------------
// nmru_queue
// Two-entry queue between the decode front and the execution back.
//------------------------------------------------------------------------------
module nmru_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  nmru_pkg::entry_t push_entry,
	input  logic             pop,
	output nmru_pkg::entry_t head,
	output logic             empty,
	output logic             full
);
	import nmru_pkg::*;

	localparam int unsigned PTR_W = $clog2(QDEPTH);

	entry_t             slot_q [QDEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     count_q;

	assign empty = count_q == '0;
	assign full  = count_q == (PTR_W+1)'(QDEPTH);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== sv/nmru_back.sv =====
//------------------------------------------------------------------------------
// nmru_back
// Timestamp banks, MRU scan, LFSR draw and the result register.
//------------------------------------------------------------------------------
`include "nmru_victim_selector_top_defines.svh"

module nmru_back #(
	parameter int unsigned NUM_SETS = 64,
	parameter int unsigned NUM_WAYS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_empty,
	input  nmru_pkg::entry_t                head,
	output logic                            pop,
	output logic                            clearing,
	input  logic                            seed_load,
	input  logic [nmru_pkg::LFSR_W-1:0]     seed_val,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// victim_way[1:0], victim_valid[2], zero pad
	output logic [nmru_pkg::OUT_W-1:0]      m_tdata
);
	import nmru_pkg::*;

	localparam int unsigned ADDR_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int unsigned WAY_W  = $clog2(NUM_WAYS);
	localparam int unsigned DIV    = NUM_WAYS - 1;
	localparam logic [63:0] RECIP64 = (64'd1 << 31) / DIV;
	localparam logic [31:0] RECIP  = RECIP64[31:0];

	typedef enum logic [1:0] {
		ST_CLR,
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

	state_t                         state_q;
	logic [ADDR_W-1:0]              clr_q;
	logic [LFSR_W-1:0]              lfsr_q;
	logic [WAY_W-1:0]               cnt_q;
	logic [WAY_W-1:0]               mru_q;
	logic [TICK_W-1:0]              best_q;
	logic                           out_valid_q;
	logic [WAYF_W-1:0]              out_way_q;
	logic                           out_flag_q;

	logic [LFSR_W+31:0]             prod_q;
	logic [LFSR_W-1:0]              lfsr_p_q;
	logic [WAY_W-1:0]               rem_q;
	logic [LFSR_W-1:0]              quo;
	logic [LFSR_W-1:0]              diff;
	logic [LFSR_W-1:0]              rem_fix;

	logic [NUM_WAYS-1:0][TICK_W-1:0] row;
	logic [ADDR_W-1:0]              waddr;
	logic [ADDR_W-1:0]              raddr;
	logic [TICK_W-1:0]              wdata;
	logic                           rd_en;
	logic                           out_room;
	logic                           out_load;
	logic [WAY_W-1:0]               victim;
	logic [TICK_W-1:0]              cur;

	assign clearing = state_q == ST_CLR;
	assign out_room = !out_valid_q || m_tready;
	assign pop      = (state_q == ST_IDLE) && !q_empty &&
	                  (head.kind == KIND_VICTIM || out_room);
	assign rd_en    = pop && head.kind == KIND_VICTIM;
	assign out_load = (pop && head.kind != KIND_VICTIM) || (state_q == ST_FIN && out_room);
	assign raddr    = ADDR_W'(head.set);
	assign waddr    = clearing ? clr_q : ADDR_W'(head.set);
	assign wdata    = clearing ? '0 : head.tick;

	for (genvar w = 0; w < NUM_WAYS; w++) begin : g_bank
		logic [TICK_W-1:0] mem [NUM_SETS];
		logic [TICK_W-1:0] rd_q;
		logic              we;

		assign we     = clearing ||
		                (pop && head.kind == KIND_WRITE && int'(head.way) == w);
		assign row[w] = rd_q;

		always_ff @(posedge clk) begin
			if (we)    mem[waddr] <= wdata;
			if (rd_en) rd_q <= mem[raddr];
		end
	end

	// remainder of the LFSR by NUM_WAYS-1 via reciprocal, two stages
	assign quo     = prod_q[LFSR_W+30:31];
	assign diff    = lfsr_p_q - LFSR_W'(quo * LFSR_W'(DIV));
	assign rem_fix = (int'(diff) >= DIV) ? diff - LFSR_W'(DIV) : diff;

	always_ff @(posedge clk) begin
		prod_q   <= (LFSR_W+32)'(lfsr_q) * (LFSR_W+32)'(RECIP);
		lfsr_p_q <= lfsr_q;
		rem_q    <= WAY_W'(rem_fix);
	end

	assign cur    = row[cnt_q];
	assign victim = (rem_q < mru_q) ? rem_q : rem_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			lfsr_q      <= SEED_RESET;
			cnt_q       <= '0;
			mru_q       <= '0;
			best_q      <= '0;
			out_valid_q <= 1'b0;
			out_way_q   <= '0;
			out_flag_q  <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			if (seed_load) lfsr_q <= seed_val;
			else if (rd_en) lfsr_q <= lfsr_step(lfsr_q);
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(NUM_SETS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (pop) begin
						if (head.kind == KIND_VICTIM) begin
							cnt_q   <= '0;
							mru_q   <= '0;
							best_q  <= '0;
							state_q <= ST_SCAN;
						end else begin
							out_way_q   <= '0;
							out_flag_q  <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					if (cur > best_q) begin
						best_q <= cur;
						mru_q  <= cnt_q;
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == WAY_W'(NUM_WAYS - 1)) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_room) begin
						out_way_q   <= WAYF_W'(victim);
						out_flag_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_W-WAYF_W-1)'(0), out_flag_q, out_way_q};

	`NMRU_ASSERT(a_lfsr_nonzero, lfsr_q != '0, "victim LFSR reached zero")
	`NMRU_ASSERT_IMP(a_victim_not_mru, state_q == ST_FIN, victim != mru_q, "victim equals MRU way")
	`NMRU_ASSERT_IMP(a_rem_range, state_q == ST_FIN, int'(rem_q) < DIV, "remainder out of range")
	`NMRU_ASSERT_IMP(a_no_pop_clearing, state_q == ST_CLR, !pop, "queue popped during clear pass")

endmodule

// ===== sv/nmru_victim_selector_top.sv =====
//------------------------------------------------------------------------------
// nmru_victim_selector_top
// Not-most-recently-used victim selector with per-way timestamp banks.
//------------------------------------------------------------------------------
// Requests arrive on the s_ stream (clear way, touch way, choose victim);
// every accepted word yields exactly one result word on the m_ stream,
// in order. Clear and touch results carry zeros; victim results carry the
// chosen way with victim_valid set. The APB port holds the LFSR seed;
// writing it reloads the LFSR (a zero seed loads 44257).
// Throughput: clear/touch one word per cycle while m_tready keeps up; a victim
// request holds the back end through the registered bank read, the
// one-way-per-cycle MRU scan and the wait for room in the result register.
// A two-entry queue sits between decode and execution, and the result
// register lets a victim request enter while a result waits on m_tready.
// A stalled m_tready backs up the queue and then drops s_tready.
// After reset the banks are zeroed one set per cycle across all NUM_SETS sets,
// with s_tready low; the APB port works throughout.
//------------------------------------------------------------------------------
module nmru_victim_selector_top #(
	parameter int unsigned NUM_SETS = 64,
	parameter int unsigned NUM_WAYS = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// req_type[1:0], set_index[7:2], way_index[9:8], now_tick[41:10], zero pad
	input  logic [nmru_pkg::IN_W-1:0]   s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// victim_way[1:0], victim_valid[2], zero pad
	output logic [nmru_pkg::OUT_W-1:0]  m_tdata,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import nmru_pkg::*;

	logic [LFSR_W-1:0] seed_q;
	logic [LFSR_W-1:0] seed_new;
	logic              seed_load;
	logic              clearing;
	logic              q_full;
	logic              q_empty;
	logic              q_push;
	logic              q_pop;
	entry_t            q_entry;
	entry_t            q_head;

	assign pready    = 1'b1;
	assign seed_new  = (pwdata[LFSR_W-1:0] == '0) ? SEED_RESET : pwdata[LFSR_W-1:0];
	assign seed_load = psel && penable && pwrite && pready && paddr[2] == REG_SEED;
	assign prdata    = (paddr[2] == REG_SEED) ? {(32-LFSR_W)'(0), seed_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
		end else if (seed_load) begin
			seed_q <= seed_new;
		end
	end

	nmru_front #(
		.NUM_SETS (NUM_SETS),
		.NUM_WAYS (NUM_WAYS)
	) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.clearing (clearing),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_entry)
	);

	nmru_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.pop        (q_pop),
		.head       (q_head),
		.empty      (q_empty),
		.full       (q_full)
	);

	nmru_back #(
		.NUM_SETS (NUM_SETS),
		.NUM_WAYS (NUM_WAYS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.head      (q_head),
		.pop       (q_pop),
		.clearing  (clearing),
		.seed_load (seed_load),
		.seed_val  (seed_new),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
